// ===== rtl/pcen_pkg.sv =====
// Shared types and constants of the polygon centroid core.
package pcen_pkg;

    // Operation handed from the vertex front end to the accumulator.
    typedef enum logic [1:0] {
        OP_EDGE,
        OP_CLOSE,
        OP_OVF
    } t_op_kind;

    localparam int OP_KIND_W = $bits(t_op_kind);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam int FIFO_DEPTH = 4;

    // Valid and overflow flags of a finished polygon job, from the accumulator to the divider.
    typedef struct packed {
        logic valid;
        logic ovf;
    } t_job_ctl;

endpackage

// ===== rtl/pcen_front.sv =====
// Vertex front end: tracks first and previous vertex, turns vertices into edge operations.
module pcen_front
    import pcen_pkg::*;
#(
    parameter int W    = 16,
    parameter int MAXV = 1024,
    parameter int CNTW = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_vertex_x,
    input  logic signed [W-1:0] i_vertex_y,
    input  logic                i_last_vertex,
    output logic                o_op_valid,
    input  logic                i_op_ready,
    output t_op_kind            o_op_kind,
    output logic signed [W-1:0] o_x0,
    output logic signed [W-1:0] o_y0,
    output logic signed [W-1:0] o_x1,
    output logic signed [W-1:0] o_y1
);

    logic signed [W-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [W-1:0] n_first_x, n_first_y, n_prev_x, n_prev_y;
    logic [CNTW-1:0]     r_count, n_count;
    logic                r_pend, n_pend;
    logic                accept;

    // A pending closing edge blocks the next vertex for one transfer.
    assign o_ready = !r_pend && i_op_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_first_x  = r_first_x;
        n_first_y  = r_first_y;
        n_prev_x   = r_prev_x;
        n_prev_y   = r_prev_y;
        n_count    = r_count;
        n_pend     = r_pend;
        o_op_valid = 1'b0;
        o_op_kind  = OP_EDGE;
        o_x0       = r_prev_x;
        o_y0       = r_prev_y;
        o_x1       = i_vertex_x;
        o_y1       = i_vertex_y;
        if (r_pend) begin
            o_op_valid = 1'b1;
            o_op_kind  = OP_CLOSE;
            o_x1       = r_first_x;
            o_y1       = r_first_y;
            if (i_op_ready) begin
                n_pend = 1'b0;
            end
        end else if (accept) begin
            if (r_count == '0) begin
                n_first_x = i_vertex_x;
                n_first_y = i_vertex_y;
                n_prev_x  = i_vertex_x;
                n_prev_y  = i_vertex_y;
                n_count   = CNTW'(1);
                if (i_last_vertex) begin
                    // lone vertex: degenerate closing edge onto itself
                    o_op_valid = 1'b1;
                    o_op_kind  = OP_CLOSE;
                    o_x0       = i_vertex_x;
                    o_y0       = i_vertex_y;
                    n_count    = '0;
                end
            end else if (r_count < CNTW'(MAXV)) begin
                o_op_valid = 1'b1;
                n_prev_x   = i_vertex_x;
                n_prev_y   = i_vertex_y;
                n_count    = r_count + 1'b1;
                if (i_last_vertex) begin
                    n_pend  = 1'b1;
                    n_count = '0;
                end
            end else if (i_last_vertex) begin
                // vertex bound exceeded somewhere in this polygon
                o_op_valid = 1'b1;
                o_op_kind  = OP_OVF;
                o_x0       = '0;
                o_y0       = '0;
                o_x1       = '0;
                o_y1       = '0;
                n_count    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_x <= n_first_x;
        r_first_y <= n_first_y;
        r_prev_x  <= n_prev_x;
        r_prev_y  <= n_prev_y;
    end

endmodule

// ===== rtl/pcen_fifo.sv =====
// Small register queue between the front end and the accumulator.
module pcen_fifo #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTRW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW:0]    r_wr, r_rd;
    logic             full, empty, push, pop;

    assign full  = (r_wr[PTRW] != r_rd[PTRW]) && (r_wr[PTRW-1:0] == r_rd[PTRW-1:0]);
    assign empty = (r_wr == r_rd);
    assign push  = i_push_valid && !full;
    assign pop   = i_pop_ready && !empty;

    assign o_push_ready = !full;
    assign o_pop_valid  = !empty;
    assign o_pop_data   = r_mem[r_rd[PTRW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr[PTRW-1:0]] <= i_push_data;
        end
    end

endmodule

// ===== rtl/pcen_accum.sv =====
// Shoelace accumulator: per-edge cross and moment products, summed over the polygon.
module pcen_accum
    import pcen_pkg::*;
#(
    parameter int W   = 16,
    parameter int AW  = 33,
    parameter int PW  = 50,
    parameter int CRW = 43,
    parameter int MW  = 60
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_op_valid,
    output logic                  o_op_ready,
    input  t_op_kind              i_op_kind,
    input  logic signed [W-1:0]   i_x0,
    input  logic signed [W-1:0]   i_y0,
    input  logic signed [W-1:0]   i_x1,
    input  logic signed [W-1:0]   i_y1,
    output t_job_ctl              o_job,
    input  logic                  i_job_ready,
    output logic signed [CRW-1:0] o_cross,
    output logic signed [MW-1:0]  o_mx,
    output logic signed [MW-1:0]  o_my
);

    localparam int SW  = W + 1;
    localparam int LO  = (AW + 1) / 2;
    localparam int HI  = AW - LO;
    localparam int PLW = SW + LO + 1;
    localparam int PHW = SW + HI;

    logic adv, blocked;

    // stage 1: coordinate products and sums
    logic                  r_s1_valid;
    t_op_kind              r_s1_kind;
    logic signed [2*W-1:0] r_s1_p1, r_s1_p2;
    logic signed [SW-1:0]  r_s1_sx, r_s1_sy;
    logic signed [2*W-1:0] p1, p2;

    // stage 2: edge cross term
    logic                 r_s2_valid;
    t_op_kind             r_s2_kind;
    logic signed [AW-1:0] r_s2_a;
    logic signed [SW-1:0] r_s2_sx, r_s2_sy;

    // stage 3: moment partial products over the split cross term
    logic                  r_s3_valid;
    t_op_kind              r_s3_kind;
    logic signed [AW-1:0]  r_s3_a;
    logic signed [PLW-1:0] r_s3_xl, r_s3_yl;
    logic signed [PHW-1:0] r_s3_xh, r_s3_yh;
    logic signed [LO:0]    a_lo;
    logic signed [HI-1:0]  a_hi;
    logic signed [PLW-1:0] pp_xl, pp_yl;
    logic signed [PHW-1:0] pp_xh, pp_yh;

    // stage 4: full moment terms
    logic                 r_s4_valid;
    t_op_kind             r_s4_kind;
    logic signed [AW-1:0] r_s4_a;
    logic signed [PW-1:0] r_s4_px, r_s4_py;

    // running sums and the finished job
    logic signed [CRW-1:0] r_cross, c_new, r_job_cross;
    logic signed [MW-1:0]  r_mx, r_my, mx_new, my_new, r_job_mx, r_job_my;
    logic                  r_job_valid, r_job_ovf;
    logic                  s4_ends;

    assign s4_ends    = r_s4_valid && (r_s4_kind != OP_EDGE);
    assign blocked    = s4_ends && r_job_valid && !i_job_ready;
    assign adv        = !blocked;
    assign o_op_ready = adv;

    assign p1 = i_x0 * i_y1;
    assign p2 = i_x1 * i_y0;

    assign a_lo  = $signed({1'b0, r_s2_a[LO-1:0]});
    assign a_hi  = r_s2_a[AW-1:LO];
    assign pp_xl = r_s2_sx * a_lo;
    assign pp_yl = r_s2_sy * a_lo;
    assign pp_xh = r_s2_sx * a_hi;
    assign pp_yh = r_s2_sy * a_hi;

    assign c_new  = r_cross + CRW'(r_s4_a);
    assign mx_new = r_mx + MW'(r_s4_px);
    assign my_new = r_my + MW'(r_s4_py);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_job_valid <= 1'b0;
            r_cross     <= '0;
            r_mx        <= '0;
            r_my        <= '0;
        end else begin
            if (r_job_valid && i_job_ready) begin
                r_job_valid <= 1'b0;
            end
            if (adv) begin
                r_s1_valid <= i_op_valid;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
                r_s4_valid <= r_s3_valid;
                if (r_s4_valid) begin
                    if (s4_ends) begin
                        r_job_valid <= 1'b1;
                        r_cross     <= '0;
                        r_mx        <= '0;
                        r_my        <= '0;
                    end else begin
                        r_cross <= c_new;
                        r_mx    <= mx_new;
                        r_my    <= my_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind <= i_op_kind;
            r_s1_p1   <= p1;
            r_s1_p2   <= p2;
            r_s1_sx   <= SW'(i_x0) + SW'(i_x1);
            r_s1_sy   <= SW'(i_y0) + SW'(i_y1);

            r_s2_kind <= r_s1_kind;
            r_s2_a    <= AW'(r_s1_p1) - AW'(r_s1_p2);
            r_s2_sx   <= r_s1_sx;
            r_s2_sy   <= r_s1_sy;

            r_s3_kind <= r_s2_kind;
            r_s3_a    <= r_s2_a;
            r_s3_xl   <= pp_xl;
            r_s3_yl   <= pp_yl;
            r_s3_xh   <= pp_xh;
            r_s3_yh   <= pp_yh;

            r_s4_kind <= r_s3_kind;
            r_s4_a    <= r_s3_a;
            r_s4_px   <= (PW'(r_s3_xh) <<< LO) + PW'(r_s3_xl);
            r_s4_py   <= (PW'(r_s3_yh) <<< LO) + PW'(r_s3_yl);

            if (s4_ends) begin
                r_job_cross <= c_new;
                r_job_mx    <= mx_new;
                r_job_my    <= my_new;
                r_job_ovf   <= (r_s4_kind == OP_OVF);
            end
        end
    end

    assign o_job.valid = r_job_valid;
    assign o_job.ovf   = r_job_ovf;
    assign o_cross     = r_job_cross;
    assign o_mx        = r_job_mx;
    assign o_my        = r_job_my;

endmodule

// ===== rtl/pcen_div.sv =====
// Back end: centroid = moment / (3 * cross sum), one quotient bit per cycle, saturated.
module pcen_div
    import pcen_pkg::*;
#(
    parameter int W    = 16,
    parameter int CRW  = 43,
    parameter int MW   = 60,
    parameter int DENW = 45,
    parameter int DW   = 60
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_job_ctl              i_job,
    output logic                  o_job_ready,
    input  logic signed [CRW-1:0] i_cross,
    input  logic signed [MW-1:0]  i_mx,
    input  logic signed [MW-1:0]  i_my,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [W-1:0]   o_centroid_x,
    output logic signed [W-1:0]   o_centroid_y,
    output logic [1:0]            o_status
);

    localparam int CTW = $clog2(DW);
    localparam logic [DW-1:0] LIM_NEG = DW'(1) << (W - 1);
    localparam logic [DW-1:0] LIM_POS = LIM_NEG - 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEN,
        S_MAG,
        S_RUN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic signed [CRW-1:0] r_cross;
    logic [MW-1:0]         r_mx, r_my;
    logic                  r_ovf;
    logic [DENW-1:0]       r_den;
    logic [DW-1:0]         r_nx, r_ny, r_d, r_remx, r_remy;
    logic                  r_negx, r_negy;
    logic [CTW-1:0]        r_cnt;
    logic [1:0]            r_status;
    logic                  r_o_valid;
    logic signed [W-1:0]   r_o_x, r_o_y;
    logic [1:0]            r_o_status;

    logic signed [DENW-1:0] c_ext, den_full;
    logic [MW-1:0]          mag_x, mag_y;
    logic [DENW-1:0]        mag_d;
    logic [DW:0]            shx, shy;
    logic                   gex, gey;
    logic [DW-1:0]          n_remx, n_remy, n_nx, n_ny;

    function automatic logic [W-1:0] f_sat(logic [DW-1:0] q, logic neg);
        logic [W-1:0] res;
        if (neg) begin
            res = (q > LIM_NEG) ? W'(LIM_NEG) : W'(DW'(0) - q);
        end else begin
            res = (q > LIM_POS) ? W'(LIM_POS) : W'(q);
        end
        return res;
    endfunction

    assign c_ext    = DENW'(r_cross);
    assign den_full = c_ext + (c_ext <<< 1);
    assign mag_x    = r_mx[MW-1] ? MW'(0) - r_mx : r_mx;
    assign mag_y    = r_my[MW-1] ? MW'(0) - r_my : r_my;
    assign mag_d    = r_den[DENW-1] ? DENW'(0) - r_den : r_den;

    // restoring division step, x and y share the divisor
    assign shx    = {r_remx, r_nx[DW-1]};
    assign shy    = {r_remy, r_ny[DW-1]};
    assign gex    = shx >= {1'b0, r_d};
    assign gey    = shy >= {1'b0, r_d};
    assign n_remx = gex ? DW'(shx - {1'b0, r_d}) : DW'(shx);
    assign n_remy = gey ? DW'(shy - {1'b0, r_d}) : DW'(shy);
    assign n_nx   = {r_nx[DW-2:0], gex};
    assign n_ny   = {r_ny[DW-2:0], gey};

    assign o_job_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job.valid) begin
                        r_cross <= i_cross;
                        r_mx    <= i_mx;
                        r_my    <= i_my;
                        r_ovf   <= i_job.ovf;
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_den   <= den_full;
                    r_nx    <= DW'(mag_x);
                    r_ny    <= DW'(mag_y);
                    r_negx  <= r_mx[MW-1];
                    r_negy  <= r_my[MW-1];
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_d    <= DW'(mag_d);
                    r_negx <= r_negx ^ r_den[DENW-1];
                    r_negy <= r_negy ^ r_den[DENW-1];
                    r_remx <= '0;
                    r_remy <= '0;
                    r_cnt  <= '0;
                    if (r_ovf) begin
                        r_status <= ST_OVF;
                        r_state  <= S_DONE;
                    end else if (r_den == '0) begin
                        r_status <= ST_ZERO;
                        r_state  <= S_DONE;
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_remx <= n_remx;
                    r_remy <= n_remy;
                    r_nx   <= n_nx;
                    r_ny   <= n_ny;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CTW'(DW - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        if (r_status == ST_OK) begin
                            r_o_x <= f_sat(r_nx, r_negx);
                            r_o_y <= f_sat(r_ny, r_negy);
                        end else begin
                            r_o_x <= '0;
                            r_o_y <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_centroid_x = r_o_x;
    assign o_centroid_y = r_o_y;
    assign o_status     = r_o_status;

endmodule

// ===== rtl/polygon_centroid_2d_core.sv =====
// Top level of the streaming polygon centroid core.
// Usage:
//   Input channel (i_valid/o_ready): one vertex per transfer, signed Q8.8 x,y;
//   i_last_vertex closes the polygon back to its first vertex.
//   Output channel (o_valid/i_ready): one result per polygon, the centroid in
//   Q8.8 truncated toward zero and saturated, plus status (ok, zero area,
//   too many vertices); centroid reads 0 unless status is ok.
// Throughput: one vertex per cycle while the queue has room; the last vertex
//   of a polygon holds the input while the closing edge is issued. The divider
//   takes one polygon at a time and runs DW divide steps on it (DW being the
//   wider of the moment and divisor widths), so short polygons are paced by it.
// Path: from the last vertex to o_valid a polygon passes the queue, the
//   accumulator stages, the job register, the setup states S_DEN and S_MAG,
//   DW divide steps and the output register.
// Reset: synchronous, active low; queue, pipeline, sums and any partial
//   polygon are dropped.
// Stall: the result waits in the output register; the divider, then the
//   accumulator pipeline, then the queue back up before o_ready drops.
module polygon_centroid_2d_core
    import pcen_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  logic                          i_last_vertex,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_centroid_x,
    output logic signed [COORD_WIDTH-1:0] o_centroid_y,
    output logic [1:0]                    o_status
);

    localparam int W    = COORD_WIDTH;
    localparam int LOGV = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int AW   = 2 * W + 1;
    localparam int PW   = 3 * W + 2;
    localparam int CRW  = (AW + LOGV > 64) ? 64 : AW + LOGV;
    localparam int MW   = (PW + LOGV > 64) ? 64 : PW + LOGV;
    localparam int DENW = (CRW + 2 > 64) ? 64 : CRW + 2;
    localparam int DW   = (MW > DENW) ? MW : DENW;
    localparam int OPW  = OP_KIND_W + 4 * W;

    logic                op_valid, op_ready;
    t_op_kind            op_kind, q_kind;
    logic signed [W-1:0] op_x0, op_y0, op_x1, op_y1;
    logic [OPW-1:0]      q_data;
    logic                q_valid, q_ready;

    t_job_ctl              job;
    logic                  job_ready;
    logic signed [CRW-1:0] job_cross;
    logic signed [MW-1:0]  job_mx, job_my;

    pcen_front #(
        .W    (W),
        .MAXV (MAX_VERTICES),
        .CNTW (CNTW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .o_op_valid    (op_valid),
        .i_op_ready    (op_ready),
        .o_op_kind     (op_kind),
        .o_x0          (op_x0),
        .o_y0          (op_y0),
        .o_x1          (op_x1),
        .o_y1          (op_y1)
    );

    pcen_fifo #(
        .WIDTH (OPW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (op_valid),
        .o_push_ready (op_ready),
        .i_push_data  ({op_kind, op_x0, op_y0, op_x1, op_y1}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    assign q_kind = t_op_kind'(q_data[OPW-1 -: OP_KIND_W]);

    pcen_accum #(
        .W   (W),
        .AW  (AW),
        .PW  (PW),
        .CRW (CRW),
        .MW  (MW)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .o_op_ready  (q_ready),
        .i_op_kind   (q_kind),
        .i_x0        (q_data[4*W-1 -: W]),
        .i_y0        (q_data[3*W-1 -: W]),
        .i_x1        (q_data[2*W-1 -: W]),
        .i_y1        (q_data[W-1:0]),
        .o_job       (job),
        .i_job_ready (job_ready),
        .o_cross     (job_cross),
        .o_mx        (job_mx),
        .o_my        (job_my)
    );

    pcen_div #(
        .W    (W),
        .CRW  (CRW),
        .MW   (MW),
        .DENW (DENW),
        .DW   (DW)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .o_job_ready  (job_ready),
        .i_cross      (job_cross),
        .i_mx         (job_mx),
        .i_my         (job_my),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_centroid_x (o_centroid_x),
        .o_centroid_y (o_centroid_y),
        .o_status     (o_status)
    );

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_centroid_x == '0) && (o_centroid_y == '0))
        else $error("centroid not zero on a failed polygon");

    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job.valid && !job_ready |=> job.valid && $stable(job_cross) && $stable(job_mx))
        else $error("finished sums changed before the divider took them");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== test/tb_polygon_centroid_2d_core.sv =====
// Testbench for the polygon centroid core: streamed polygons checked against a shoelace predictor.
`timescale 1ns / 1ps

module tb_polygon_centroid_2d_core
    import pcen_pkg::*;
;

    localparam int COORD_W    = 16;
    localparam int MAX_VERTS  = 1024;
    localparam int DRAIN_WAIT = 150;

    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [1:0]                status;
    } t_centroid;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic signed [COORD_W-1:0] i_vertex_x = '0;
    logic signed [COORD_W-1:0] i_vertex_y = '0;
    logic                      i_last_vertex = 1'b0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [COORD_W-1:0] o_centroid_x;
    logic signed [COORD_W-1:0] o_centroid_y;
    logic [1:0]                o_status;

    polygon_centroid_2d_core #(
        .MAX_VERTICES(MAX_VERTS),
        .COORD_WIDTH (COORD_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_vertex_x   (i_vertex_x),
        .i_vertex_y   (i_vertex_y),
        .i_last_vertex(i_last_vertex),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_centroid_x (o_centroid_x),
        .o_centroid_y (o_centroid_y),
        .o_status     (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Predicted centroids, oldest first
    t_centroid centroid_q[$];

    // Vertices of the polygon being built
    logic signed [COORD_W-1:0] poly_xs[$];
    logic signed [COORD_W-1:0] poly_ys[$];

    int send_idle_pct = 21;
    int recv_idle_pct = 63;
    int error_count = 0;
    int vertices_sent = 0;
    int polygons_sent = 0;
    int centroids_checked = 0;
    int status_seen[3] = '{0, 0, 0};

    // Predictor state: sums wrap modulo 2^64
    logic signed [63:0] ring_first_x, ring_first_y, ring_prev_x, ring_prev_y;
    logic [63:0]        area2_sum, mom_x_sum, mom_y_sum;
    int unsigned        ring_count;
    bit                 ring_overflow;

    function automatic void clear_ring();
        ring_first_x  = '0;
        ring_first_y  = '0;
        ring_prev_x   = '0;
        ring_prev_y   = '0;
        area2_sum     = '0;
        mom_x_sum     = '0;
        mom_y_sum     = '0;
        ring_count    = 0;
        ring_overflow = 1'b0;
    endfunction

    function automatic void accumulate_edge(logic signed [63:0] x0, logic signed [63:0] y0,
                                            logic signed [63:0] x1, logic signed [63:0] y1);
        logic signed [63:0] edge_cross;
        edge_cross = x0 * y1 - x1 * y0;
        area2_sum  = area2_sum + edge_cross;
        mom_x_sum  = mom_x_sum + (x0 + x1) * edge_cross;
        mom_y_sum  = mom_y_sum + (y0 + y1) * edge_cross;
    endfunction

    // Signed quotient truncated toward zero, clamped to the coordinate range
    function automatic logic signed [COORD_W-1:0] clamp_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] n, d, q;
        n = num[63] ? -num : num;
        d = den[63] ? -den : den;
        q = n / d;
        if (num[63] != den[63]) begin
            if (q > 64'd32768) q = 64'd32768;
            return -q[COORD_W-1:0];
        end
        if (q > 64'd32767) q = 64'd32767;
        return q[COORD_W-1:0];
    endfunction

    function automatic void take_vertex(logic signed [COORD_W-1:0] vx,
                                        logic signed [COORD_W-1:0] vy, logic last);
        logic signed [63:0] sx, sy;
        logic [63:0]        den;
        t_centroid          res;
        sx = 64'(vx);
        sy = 64'(vy);
        if (ring_count == 0) begin
            ring_first_x = sx;
            ring_first_y = sy;
            ring_prev_x  = sx;
            ring_prev_y  = sy;
            ring_count   = 1;
        end else if (ring_count < MAX_VERTS) begin
            accumulate_edge(ring_prev_x, ring_prev_y, sx, sy);
            ring_prev_x = sx;
            ring_prev_y = sy;
            ring_count++;
        end else begin
            ring_overflow = 1'b1;
        end
        if (!last) return;
        res.cx = '0;
        res.cy = '0;
        if (ring_overflow) begin
            res.status = ST_OVF;
        end else begin
            accumulate_edge(ring_prev_x, ring_prev_y, ring_first_x, ring_first_y);
            den = area2_sum * 64'd3;
            if (den == 0) begin
                res.status = ST_ZERO;
            end else begin
                res.cx     = clamp_div(mom_x_sum, den);
                res.cy     = clamp_div(mom_y_sum, den);
                res.status = ST_OK;
            end
        end
        centroid_q.push_back(res);
        clear_ring();
    endfunction

    // One vertex transfer; valid stays up on return so a back-to-back vertex
    // needs no second assignment in the same step.
    task automatic send_vertex(input logic signed [COORD_W-1:0] vx,
                               input logic signed [COORD_W-1:0] vy, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_vertex_x    <= vx;
        i_vertex_y    <= vy;
        i_last_vertex <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        take_vertex(vx, vy, last);
        vertices_sent++;
    endtask

    task automatic add_pt(input int vx, input int vy);
        poly_xs.push_back(COORD_W'(vx));
        poly_ys.push_back(COORD_W'(vy));
    endtask

    task automatic flush_polygon();
        for (int k = 0; k < poly_xs.size(); k++)
            send_vertex(poly_xs[k], poly_ys[k], k == poly_xs.size() - 1);
        poly_xs.delete();
        poly_ys.delete();
        polygons_sent++;
    endtask

    task automatic test_directed();
        // single vertex: closing edge of zero length
        add_pt(0, 0);
        flush_polygon();
        // counterclockwise and clockwise triangles
        add_pt(0, 0); add_pt(768, 0); add_pt(0, 768);
        flush_polygon();
        add_pt(0, 768); add_pt(768, 0); add_pt(0, 0);
        flush_polygon();
        // square spanning the full coordinate range
        add_pt(-32768, -32768); add_pt(32767, -32768);
        add_pt(32767, 32767);   add_pt(-32768, 32767);
        flush_polygon();
        // collinear points and a two-vertex polygon: zero area
        add_pt(100, 100); add_pt(200, 200); add_pt(300, 300);
        flush_polygon();
        add_pt(-32768, 32767); add_pt(32767, -32768);
        flush_polygon();
        // lopsided bow-ties: tiny net area, large moments, clamp at both ends
        add_pt(0, 0); add_pt(32767, 32767); add_pt(32767, 0); add_pt(0, 32760);
        flush_polygon();
        add_pt(0, 0); add_pt(-32767, 32767); add_pt(-32767, 0); add_pt(0, 32760);
        flush_polygon();
    endtask

    task automatic test_random_polygons(input int item_budget);
        int                        sent, n, shape, span;
        logic signed [COORD_W-1:0] cx, cy, vx, vy;
        sent = 0;
        while (sent < item_budget) begin
            shape = $urandom_range(99);
            if (shape < 80)      n = $urandom_range(3, 8);
            else if (shape < 90) n = $urandom_range(1, 2);
            else                 n = $urandom_range(3, 6);
            span = $urandom_range(1) ? 0 : $urandom_range(1, 2047);
            cx   = 16'($urandom_range(65535));
            cy   = 16'($urandom_range(65535));
            for (int k = 0; k < n; k++) begin
                if (span == 0) begin
                    vx = 16'($urandom_range(65535));
                    vy = 16'($urandom_range(65535));
                end else begin
                    vx = cx + 16'($urandom_range(2 * span) - span);
                    vy = cy + 16'($urandom_range(2 * span) - span);
                end
                // degenerate ring: all vertices on one horizontal line
                if (shape >= 90) vy = cy;
                add_pt(int'(vx), int'(vy));
            end
            flush_polygon();
            sent += n;
        end
    endtask

    // Result side: random backpressure and in-order compare
    always @(posedge i_clk) begin
        t_centroid want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (centroid_q.size() == 0) begin
                    $display("%0t: centroid with nothing expected: x=%0d y=%0d status=%0d",
                             $time, o_centroid_x, o_centroid_y, o_status);
                    error_count++;
                end else begin
                    want = centroid_q.pop_front();
                    if (o_centroid_x !== want.cx) begin
                        $display("%0t: centroid_x expected %0d actual %0d",
                                 $time, want.cx, o_centroid_x);
                        error_count++;
                    end
                    if (o_centroid_y !== want.cy) begin
                        $display("%0t: centroid_y expected %0d actual %0d",
                                 $time, want.cy, o_centroid_y);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        error_count++;
                    end
                    if (want.status <= ST_OVF) status_seen[want.status]++;
                    centroids_checked++;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d centroids outstanding", centroid_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        clear_ring();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 63;
        test_directed();
        test_random_polygons(210);

        send_idle_pct = 63;
        recv_idle_pct = 21;
        test_random_polygons(210);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_polygons(210);

        i_valid <= 1'b0;
        while (centroid_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d vertices in %0d polygons; %0d centroids compared",
                 vertices_sent, polygons_sent, centroids_checked);
        $display("Status mix: %0d ok, %0d zero area, %0d over vertex bound",
                 status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_OVF]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== polygon_centroid_2d_core.f =====
rtl/pcen_pkg.sv
rtl/pcen_front.sv
rtl/pcen_fifo.sv
rtl/pcen_accum.sv
rtl/pcen_div.sv
rtl/polygon_centroid_2d_core.sv
test/tb_polygon_centroid_2d_core.sv
